// ----- sv/nearest_point_lookup_assert.svh -----
// Assertion macros for the nearest point lookup checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef NEAREST_POINT_LOOKUP_ASSERT_SVH
`define NEAREST_POINT_LOOKUP_ASSERT_SVH

// Same-cycle implication, off during reset
`define NPL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define NPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked through reset
`define NPL_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/npl_pkg.sv -----
// Shared types and constants for the nearest point lookup block.
// No dependencies; used by all RTL and checker files.
package npl_pkg;

  localparam int MAX_POINTS_DEF = 4096;

  localparam int COORD_W = 24;
  localparam int VALUE_W = 20;
  localparam int CMD_W   = 2;
  localparam int DIST_W  = 51;
  localparam int OUT_IDX_W = 12;
  localparam int ABS_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int ENTRY_W = 2 * COORD_W + VALUE_W;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  localparam logic [DIST_W-1:0] MAX_DIST_SQ_RST = DIST_W'(64'd100000000000);

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic vld;
    logic last;
  } npl_ctl_t;

endpackage

// ----- sv/nearest_point_lookup.sv -----
// Nearest point lookup: point table in one memory, scan sequencer, best-match tracking.
// Depends on npl_pkg and npl_dist.
//
// Load and clear items give no result. A query scans the stored points one per cycle
// through the single table read port and the shared squared distance unit, so it
// holds s_tready low until its result is loaded into the output register. A finished
// result waits in the output register while loads and clears go on; a later query
// waits for that register to empty before it finishes.
module nearest_point_lookup #(
  parameter int MAX_POINTS = npl_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [npl_pkg::DIST_W-1:0]         cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [npl_pkg::IN_DATA_W-1:0]      s_tdata,  // x_coord, y_coord, point_value, zero pad
  input  logic [npl_pkg::CMD_W-1:0]          s_tuser,  // cmd
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [npl_pkg::OUT_DATA_W-1:0]     m_tdata,  // nearest_value, nearest_index
  output logic                               m_tuser   // found
);
  import npl_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [DIST_W-1:0]  max_dist_sq;
  logic [CNT_W-1:0]   point_count;
  logic [CNT_W-1:0]   issue_cnt;
  logic               accept;
  logic               out_load;
  logic               issue_last;

  logic [ENTRY_W-1:0] mem [MAX_POINTS];
  logic [ENTRY_W-1:0] rd_q;
  npl_ctl_t           rd_ctl;
  logic [IDX_W-1:0]   rd_idx;

  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;

  npl_ctl_t           d_ctl;
  logic [SQ_W-1:0]    d_sqx;
  logic [SQ_W-1:0]    d_sqy;
  logic signed [VALUE_W-1:0] d_val;
  logic [IDX_W-1:0]   d_idx;
  logic [DIST_W-1:0]  cand_d;
  logic               better;

  logic [DIST_W-1:0]  best_d;
  logic               best_found;
  logic [IDX_W-1:0]   best_idx;
  logic signed [VALUE_W-1:0] best_val;
  logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_load   = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign issue_last = (CNT_W'(issue_cnt + 1'b1) == point_count);

  assign cand_d = DIST_W'({1'b0, d_sqx}) + DIST_W'({1'b0, d_sqy});
  assign better = d_ctl.vld && (cand_d < best_d);
  assign idx_ext = {{OUT_IDX_W{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist_sq <= MAX_DIST_SQ_RST;
    end else if (cfg_we) begin
      max_dist_sq <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser == CMD_QUERY) begin
          state_next = (point_count == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (d_ctl.vld && d_ctl.last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      issue_cnt   <= '0;
      rd_ctl      <= '0;
    end else begin
      state  <= state_next;
      rd_ctl <= '{vld: (state == ST_SCAN), last: (state == ST_SCAN) && issue_last};
      if (accept && s_tuser == CMD_LOAD && point_count < CNT_W'(MAX_POINTS)) begin
        point_count <= point_count + 1'b1;
      end else if (accept && s_tuser == CMD_CLEAR) begin
        point_count <= '0;
      end
      if (state == ST_SCAN) begin
        issue_cnt <= issue_cnt + 1'b1;
      end else begin
        issue_cnt <= '0;
      end
    end
  end

  // table memory: write on load, registered read during scan
  always_ff @(posedge clk) begin
    if (accept && s_tuser == CMD_LOAD && point_count < CNT_W'(MAX_POINTS)) begin
      mem[point_count[IDX_W-1:0]] <= s_tdata[ENTRY_W-1:0];
    end
    if (state == ST_SCAN) begin
      rd_q <= mem[issue_cnt[IDX_W-1:0]];
    end
    rd_idx <= issue_cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == CMD_QUERY) begin
      qx <= s_tdata[COORD_W-1:0];
      qy <= s_tdata[2*COORD_W-1:COORD_W];
    end
  end

  npl_dist #(
    .IDX_W(IDX_W)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (rd_ctl),
    .in_x   (rd_q[COORD_W-1:0]),
    .in_y   (rd_q[2*COORD_W-1:COORD_W]),
    .in_val (rd_q[ENTRY_W-1:2*COORD_W]),
    .in_idx (rd_idx),
    .qx     (qx),
    .qy     (qy),
    .out_ctl(d_ctl),
    .out_sqx(d_sqx),
    .out_sqy(d_sqy),
    .out_val(d_val),
    .out_idx(d_idx)
  );

  // keep the first strictly nearer point
  always_ff @(posedge clk) begin
    if (accept && s_tuser == CMD_QUERY) begin
      best_d     <= max_dist_sq;
      best_found <= 1'b0;
      best_idx   <= '0;
      best_val   <= '0;
    end else if (better) begin
      best_d     <= cand_d;
      best_found <= 1'b1;
      best_idx   <= d_idx;
      best_val   <= d_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {idx_ext[OUT_IDX_W-1:0], best_val};
      m_tuser <= best_found;
    end
  end

endmodule

// ----- sv/npl_dist.sv -----
// Squared distance unit: absolute differences, then squares, two register stages.
// Depends on npl_pkg.
module npl_dist #(
  parameter int IDX_W = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  npl_pkg::npl_ctl_t                in_ctl,
  input  logic signed [npl_pkg::COORD_W-1:0] in_x,
  input  logic signed [npl_pkg::COORD_W-1:0] in_y,
  input  logic signed [npl_pkg::VALUE_W-1:0] in_val,
  input  logic [IDX_W-1:0]                 in_idx,
  input  logic signed [npl_pkg::COORD_W-1:0] qx,
  input  logic signed [npl_pkg::COORD_W-1:0] qy,
  output npl_pkg::npl_ctl_t                out_ctl,
  output logic [npl_pkg::SQ_W-1:0]         out_sqx,
  output logic [npl_pkg::SQ_W-1:0]         out_sqy,
  output logic signed [npl_pkg::VALUE_W-1:0] out_val,
  output logic [IDX_W-1:0]                 out_idx
);
  import npl_pkg::*;

  logic signed [ABS_W-1:0] dx;
  logic signed [ABS_W-1:0] dy;
  logic [ABS_W-1:0]        ax;
  logic [ABS_W-1:0]        ay;
  npl_ctl_t                a_ctl;
  logic signed [VALUE_W-1:0] a_val;
  logic [IDX_W-1:0]        a_idx;

  assign dx = {in_x[COORD_W-1], in_x} - {qx[COORD_W-1], qx};
  assign dy = {in_y[COORD_W-1], in_y} - {qy[COORD_W-1], qy};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      out_ctl <= '0;
    end else begin
      a_ctl   <= in_ctl;
      out_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    ax      <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ay      <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    a_val   <= in_val;
    a_idx   <= in_idx;
    out_sqx <= ax * ax;
    out_sqy <= ay * ay;
    out_val <= a_val;
    out_idx <= a_idx;
  end

endmodule

// ----- sv/npl_checker.sv -----
// Port-level checker for nearest_point_lookup, bound to the top level.
// Depends on npl_pkg and nearest_point_lookup_assert.svh.
`include "nearest_point_lookup_assert.svh"

module npl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [npl_pkg::CMD_W-1:0]      s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [npl_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser
);
  import npl_pkg::*;

  `NPL_ASSERT_NEXT_ALWAYS(a_reset_clears, rst, !m_tvalid && s_tready, "reset did not clear")
  `NPL_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss with nonzero data")
  `NPL_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser == CMD_QUERY, !s_tready, "ready during query")
  `NPL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled item changed")

endmodule

bind nearest_point_lookup npl_checker u_npl_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for nearest_point_lookup: loads points, queries them and clears the
// table while both stream sides idle at random in most phases, and predicts every query answer in-house.
// Depends on npl_pkg and the nearest_point_lookup RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import npl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] LIMIT_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [OUT_IDX_W-1:0]      index;
    logic                      found;
  } nearest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [DIST_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;

  // in-house copy of the point table
  logic signed [COORD_W-1:0] pt_x [MAX_POINTS_DEF];
  logic signed [COORD_W-1:0] pt_y [MAX_POINTS_DEF];
  logic signed [VALUE_W-1:0] pt_val [MAX_POINTS_DEF];
  int unsigned pt_count = 0;
  logic [DIST_W-1:0] limit_sq = MAX_DIST_SQ_RST;

  nearest_t nearest_q[$];
  int errors = 0;
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  int hold_req = 0;

  nearest_point_lookup u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("** nearest_point_lookup: FAILED **");
    $finish;
  end

  function automatic void apply_item(logic [CMD_W-1:0] cmd, logic signed [COORD_W-1:0] qx,
                                     logic signed [COORD_W-1:0] qy,
                                     logic signed [VALUE_W-1:0] v);
    longint dx;
    longint dy;
    longint unsigned d;
    longint unsigned best;
    nearest_t r;
    case (cmd)
      CMD_LOAD: begin
        if (pt_count < MAX_POINTS_DEF) begin
          pt_x[pt_count] = qx;
          pt_y[pt_count] = qy;
          pt_val[pt_count] = v;
          pt_count++;
        end
      end
      CMD_CLEAR: pt_count = 0;
      CMD_QUERY: begin
        r = '0;
        best = limit_sq;
        for (int j = 0; j < pt_count; j++) begin
          dx = longint'(pt_x[j]) - longint'(qx);
          dy = longint'(pt_y[j]) - longint'(qy);
          d = dx * dx + dy * dy;
          if (d < best) begin
            best = d;
            r.found = 1'b1;
            r.index = OUT_IDX_W'(j);
            r.value = pt_val[j];
          end
        end
        nearest_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [COORD_W-1:0] qx,
                           logic signed [COORD_W-1:0] qy, logic signed [VALUE_W-1:0] v);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'b0, v, qy, qx};
    do @(posedge clk); while (!s_tready);
    apply_item(cmd, qx, qy, v);
  endtask

  // drop valid and wait until every query answer is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_limit(logic [DIST_W-1:0] lim);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_sq = lim;
  endtask

  initial begin : result_checker
    nearest_t exp_r;
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (nearest_q.size() == 0) begin
          $error("unexpected result: value %0d index %0d found %0b",
                 $signed(m_tdata[VALUE_W-1:0]), m_tdata[VALUE_W +: OUT_IDX_W], m_tuser);
          errors++;
        end else begin
          exp_r = nearest_q.pop_front();
          if ($signed(m_tdata[VALUE_W-1:0]) != exp_r.value) begin
            $error("nearest_value: expected %0d, got %0d", exp_r.value,
                   $signed(m_tdata[VALUE_W-1:0]));
            errors++;
          end
          if (m_tdata[VALUE_W +: OUT_IDX_W] != exp_r.index) begin
            $error("nearest_index: expected %0d, got %0d", exp_r.index,
                   m_tdata[VALUE_W +: OUT_IDX_W]);
            errors++;
          end
          if (m_tuser != exp_r.found) begin
            $error("found: expected %0b, got %0b", exp_r.found, m_tuser);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic test_empty_table();
    send_item(CMD_QUERY, 24'sd0, 24'sd0, 20'sd0);
    send_item(CMD_UNUSED, 24'sd5, -24'sd5, 20'sd9);
    send_item(CMD_CLEAR, 24'sd0, 24'sd0, 20'sd0);
    send_item(CMD_QUERY, -24'sd1, 24'sd1, -20'sd1);
    drain();
  endtask

  task automatic test_extremes_and_ties();
    send_item(CMD_LOAD, -24'sd8388608, 24'sd8388607, -20'sd524288);
    send_item(CMD_LOAD, 24'sd8388607, -24'sd8388608, 20'sd524287);
    send_item(CMD_LOAD, 24'sd100, 24'sd0, 20'sd11);
    send_item(CMD_LOAD, -24'sd100, 24'sd0, 20'sd22);
    send_item(CMD_LOAD, 24'sd100, 24'sd0, 20'sd33);
    send_item(CMD_QUERY, 24'sd0, 24'sd0, 20'sd0);
    send_item(CMD_QUERY, 24'sd100, 24'sd0, 20'sd0);
    send_item(CMD_QUERY, -24'sd8388608, 24'sd8388607, 20'sd0);
    send_item(CMD_QUERY, 24'sd8388607, -24'sd8388608, 20'sd0);
    send_item(CMD_QUERY, 24'sd4000000, 24'sd4000000, 20'sd0);
    drain();
  endtask

  task automatic test_limits();
    set_limit('0);
    send_item(CMD_QUERY, 24'sd100, 24'sd0, 20'sd0);
    set_limit(LIMIT_MAX);
    send_item(CMD_QUERY, 24'sd8388607, 24'sd8388607, 20'sd0);
    send_item(CMD_CLEAR, 24'sd0, 24'sd0, 20'sd0);
    set_limit(51'd25);
    send_item(CMD_LOAD, 24'sd3, 24'sd4, 20'sd7);
    send_item(CMD_QUERY, 24'sd0, 24'sd0, 20'sd0);
    send_item(CMD_LOAD, 24'sd3, 24'sd3, 20'sd8);
    send_item(CMD_QUERY, 24'sd0, 24'sd0, 20'sd0);
    set_limit(MAX_DIST_SQ_RST);
  endtask

  task automatic test_crowded_table();
    src_idle = 1'b0;
    send_item(CMD_CLEAR, 24'sd0, 24'sd0, 20'sd0);
    for (int j = 0; j < 32; j++)
      send_item(CMD_LOAD, COORD_W'(j), COORD_W'(-j), VALUE_W'($urandom));
    repeat (3) send_item(CMD_LOAD, -24'sd5000000, 24'sd5000000, 20'sd77);
    send_item(CMD_QUERY, -24'sd5000000, 24'sd5000000, 20'sd0);
    send_item(CMD_QUERY, 24'sd4095, -24'sd4095, 20'sd0);
    send_item(CMD_QUERY, 24'sd0, 24'sd0, 20'sd0);
    send_item(CMD_QUERY, 24'sd2000, -24'sd2000, 20'sd0);
    send_item(CMD_CLEAR, 24'sd0, 24'sd0, 20'sd0);
    send_item(CMD_QUERY, 24'sd0, 24'sd0, 20'sd0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 300;
    for (int j = 0; j < 3; j++)
      send_item(CMD_LOAD, COORD_W'(10 * j), 24'sd0, VALUE_W'($urandom));
    for (int j = 0; j < 4; j++)
      send_item(CMD_QUERY, COORD_W'(10 * j), 24'sd1, 20'sd0);
    send_item(CMD_LOAD, 24'sd5, 24'sd5, 20'sd5);
    send_item(CMD_QUERY, 24'sd5, 24'sd4, 20'sd0);
    drain();
  endtask

  task automatic test_random(int n, int span, bit full_range);
    logic [CMD_W-1:0] cmd;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    int r;
    int k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) cmd = CMD_LOAD;
      else if (r < 85) cmd = CMD_QUERY;
      else if (r < 92) cmd = CMD_CLEAR;
      else if (r < 95) cmd = CMD_UNUSED;
      else cmd = CMD_LOAD;
      if (full_range && $urandom_range(0, 2) == 0) begin
        qx = COORD_W'($urandom);
        qy = COORD_W'($urandom);
      end else if (pt_count > 0 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, pt_count - 1);
        qx = pt_x[k] + COORD_W'(int'($urandom_range(0, 6)) - 3);
        qy = pt_y[k] + COORD_W'(int'($urandom_range(0, 6)) - 3);
      end else begin
        qx = COORD_W'(int'($urandom_range(0, 2 * span)) - span);
        qy = COORD_W'(int'($urandom_range(0, 2 * span)) - span);
      end
      send_item(cmd, qx, qy, VALUE_W'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle = 1'b1;
    sink_idle = 1'b1;
    test_empty_table();
    test_extremes_and_ties();
    test_limits();
    test_crowded_table();
    src_idle = 1'b1;
    test_backpressure();
    set_limit(MAX_DIST_SQ_RST);
    test_random(18, 400000, 1'b0);
    set_limit(DIST_W'($urandom_range(1, 5000)));
    test_random(18, 60, 1'b0);
    set_limit(LIMIT_MAX);
    test_random(18, 8000000, 1'b1);
    set_limit(DIST_W'({$urandom, $urandom}));
    src_idle = 1'b0;
    sink_idle = 1'b0;
    test_random(18, 2000000, 1'b1);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("** nearest_point_lookup: PASSED **");
    else
      $display("** nearest_point_lookup: FAILED **");
    $finish;
  end
endmodule
